[sv/obd_prd_pkg.sv]
// ============================================================================
// obd_prd_pkg
// Shared types, constants and helper functions for the OBD-II PID decoder.
// ============================================================================
`default_nettype none

package obd_prd_pkg;

    // Characters that matter to the parser
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_HDR = 2'd1;
    localparam logic [1:0] ST_UNK    = 2'd2;
    localparam logic [1:0] ST_SHORT  = 2'd3;

    // Decoded PIDs
    localparam logic [7:0] PID_LOAD     = 8'h04;
    localparam logic [7:0] PID_COOLANT  = 8'h05;
    localparam logic [7:0] PID_FUELTRIM = 8'h07;
    localparam logic [7:0] PID_MAP      = 8'h0B;
    localparam logic [7:0] PID_RPM      = 8'h0C;
    localparam logic [7:0] PID_SPEED    = 8'h0D;
    localparam logic [7:0] PID_TIMING   = 8'h0E;
    localparam logic [7:0] PID_THROTTLE = 8'h11;
    localparam logic [7:0] PID_VOLTAGE  = 8'h42;

    localparam int VALUE_W = 23;

    // floor(x/125) == (x * VOLT_RECIP) >> VOLT_SHIFT for x < 2**21
    localparam logic [21:0] VOLT_RECIP = 22'd2147484;
    localparam int          VOLT_SHIFT = 28;

    // Snapshot of the parse state taken on the last character
    typedef struct packed {
        logic             have_pid;
        logic [1:0][7:0]  pid_chars;
        logic [3:0][7:0]  data_chars;
        logic [2:0]       data_cnt;
    } t_snap;

    // {is_digit, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_0 && c <= CH_9) begin
                d = c - CH_0;
                return {1'b1, d[3:0]};
            end
            if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    // Two-character base-16 read, strtoul style, kept to 8 bits
    function automatic logic [7:0] parse_pair(input logic [7:0] c0, input logic [7:0] c1);
        logic [4:0] h0;
        logic [4:0] h1;
        begin
            h0 = hex_val(c0);
            h1 = hex_val(c1);
            if (h0[4]) begin
                return h1[4] ? {h0[3:0], h1[3:0]} : {4'd0, h0[3:0]};
            end
            if (c0 inside {CH_TAB, CH_VT, CH_FF, CH_PLUS}) begin
                return h1[4] ? {4'd0, h1[3:0]} : 8'd0;
            end
            if (c0 == CH_MINUS) begin
                return h1[4] ? (8'd0 - {4'd0, h1[3:0]}) : 8'd0;
            end
            return 8'd0;
        end
    endfunction

endpackage

`default_nettype wire

[sv/obd_prd_parser.sv]
// ============================================================================
// obd_prd_parser
// Character cleaner and header/PID/data tracker; snapshots the parse state on
// the last character of a response into a one-entry stage register.
// ============================================================================
`default_nettype none

module obd_prd_parser
    import obd_prd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_response,
    output logic            o_snap_valid,
    input  wire logic       i_snap_ready,
    output t_snap           o_snap
);

    typedef enum logic [1:0] {PH_SEARCH, PH_PID, PH_DATA} t_phase;

    t_phase          r_phase, n_phase;
    logic            r_prev4, n_prev4;
    logic            r_pid_idx, n_pid_idx;
    logic [1:0][7:0] r_pid, n_pid;
    logic [3:0][7:0] r_data, n_data;
    logic [2:0]      r_data_cnt, n_data_cnt;
    logic            r_snap_valid;
    t_snap           r_snap;

    logic       accept;
    logic       keep;
    logic [7:0] c_up;

    assign o_ready      = !r_snap_valid || i_snap_ready;
    assign accept       = i_valid && o_ready;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    always_comb begin
        keep = !(i_char_code inside {CH_SPACE, CH_GT, CH_CR, CH_LF});
        c_up = (i_char_code inside {[CH_LA:CH_LZ]}) ? i_char_code - CASE_OFS : i_char_code;

        n_phase    = r_phase;
        n_prev4    = r_prev4;
        n_pid_idx  = r_pid_idx;
        n_pid      = r_pid;
        n_data     = r_data;
        n_data_cnt = r_data_cnt;

        if (keep) begin
            case (r_phase)
                PH_PID: begin
                    n_pid[r_pid_idx] = c_up;
                    n_pid_idx        = !r_pid_idx;
                    if (r_pid_idx) begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    // characters past the fourth data character are dropped
                    if (!r_data_cnt[2]) begin
                        n_data[r_data_cnt[1:0]] = c_up;
                        n_data_cnt              = r_data_cnt + 3'd1;
                    end
                end
                default: begin
                    if (c_up == CH_1 && r_prev4) begin
                        n_phase = PH_PID;
                    end
                    n_prev4 = (c_up == CH_4);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEARCH;
            r_prev4      <= 1'b0;
            r_pid_idx    <= 1'b0;
            r_data_cnt   <= 3'd0;
            r_snap_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pid  <= n_pid;
                r_data <= n_data;
                if (i_end_of_response) begin
                    r_phase    <= PH_SEARCH;
                    r_prev4    <= 1'b0;
                    r_pid_idx  <= 1'b0;
                    r_data_cnt <= 3'd0;
                end else begin
                    r_phase    <= n_phase;
                    r_prev4    <= n_prev4;
                    r_pid_idx  <= n_pid_idx;
                    r_data_cnt <= n_data_cnt;
                end
            end
            if (o_ready) begin
                r_snap_valid <= accept && i_end_of_response;
                if (accept && i_end_of_response) begin
                    r_snap.have_pid   <= (n_phase == PH_DATA);
                    r_snap.pid_chars  <= n_pid;
                    r_snap.data_chars <= n_data;
                    r_snap.data_cnt   <= n_data_cnt;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/obd_prd_decoder.sv]
// ============================================================================
// obd_prd_decoder
// Turns a response snapshot into status, PID and Q8 value; holds the result
// register and the sticky online/offline flags.
// ============================================================================
`default_nettype none

module obd_prd_decoder
    import obd_prd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_snap_valid,
    output logic                           o_snap_ready,
    input  wire t_snap                     i_snap,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [1:0]                     o_status,
    output logic [7:0]                     o_pid_code,
    output logic signed [VALUE_W-1:0]      o_value_q8,
    output logic                           o_online_seen,
    output logic                           o_offline_seen
);

    logic                      r_valid;
    logic [1:0]                r_status;
    logic [7:0]                r_pid;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_online;
    logic                      r_offline;

    logic                      take;
    logic [7:0]                pid;
    logic [7:0]                a;
    logic [7:0]                b;
    logic [15:0]               w;
    logic [20:0]               volt_x;
    logic [42:0]               volt_prod;
    logic [14:0]               a100;
    logic [15:0]               div255_sum;
    logic [14:0]               pct_q8;
    logic [15:0]               a200;
    logic signed [23:0]        val;
    logic                      known;
    logic                      need4;
    logic                      short_data;
    logic [1:0]                status;

    assign o_snap_ready = !r_valid || i_ready;
    assign take         = i_snap_valid && o_snap_ready;

    always_comb begin
        pid = parse_pair(i_snap.pid_chars[0], i_snap.pid_chars[1]);
        a   = parse_pair(i_snap.data_chars[0], i_snap.data_chars[1]);
        b   = parse_pair(i_snap.data_chars[2], i_snap.data_chars[3]);
        w   = {a, b};

        volt_x    = {w, 5'd0};
        volt_prod = 43'(volt_x) * 43'(VOLT_RECIP);

        // a*25600/255 = a*100 + a*100/255; the second term by the 255 trick
        a100       = 15'({7'd0, a} * 15'd100);
        div255_sum = 16'(a100) + 16'(a100 >> 8) + 16'd1;
        pct_q8     = a100 + 15'(div255_sum[15:8]);

        a200 = 16'(a) * 16'd200;

        known = 1'b1;
        need4 = 1'b0;
        val   = 24'sd0;
        case (pid)
            PID_RPM: begin
                need4 = 1'b1;
                val   = $signed({2'd0, w[15:2], 8'd0});
            end
            PID_SPEED, PID_MAP: val = $signed({8'd0, a, 8'd0});
            PID_COOLANT:        val = ($signed({16'd0, a}) - 24'sd40) <<< 8;
            PID_LOAD, PID_THROTTLE: val = $signed({9'd0, pct_q8});
            PID_TIMING:         val = $signed({9'd0, a, 7'd0}) - 24'sd16384;
            PID_VOLTAGE: begin
                need4 = 1'b1;
                val   = $signed({9'd0, volt_prod[VOLT_SHIFT +: 15]});
            end
            PID_FUELTRIM:       val = $signed({8'd0, a200}) - 24'sd25600;
            default:            known = 1'b0;
        endcase

        short_data = need4 ? !i_snap.data_cnt[2] : (i_snap.data_cnt < 3'd2);

        if (!i_snap.have_pid) begin
            status = ST_NO_HDR;
        end else if (!known) begin
            status = ST_UNK;
        end else if (short_data) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_online  <= 1'b0;
            r_offline <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_valid <= i_snap_valid;
            end
            if (take) begin
                r_status  <= status;
                r_pid     <= i_snap.have_pid ? pid : 8'd0;
                r_value   <= (status == ST_OK) ? VALUE_W'(val) : '0;
                r_online  <= r_online || i_snap.have_pid;
                r_offline <= r_offline || !i_snap.have_pid;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_pid_code     = r_pid;
    assign o_value_q8     = r_value;
    assign o_online_seen  = r_online;
    assign o_offline_seen = r_offline;

endmodule

`default_nettype wire

[sv/obd_pid_response_decoder_top.sv]
// ============================================================================
// obd_pid_response_decoder_top
// OBD-II mode 01 response decoder: ASCII characters in, one decoded result
// per response out.
// ============================================================================
//  Channel   Handshake          Payload
//  input     i_valid/o_ready    i_char_code, i_end_of_response
//  output    o_valid/i_ready    o_status, o_pid_code, o_value_q8,
//                               o_online_seen, o_offline_seen
//
//  One character per cycle while o_ready is high. The last character of a
//  response goes through the snapshot register, then the result register.
//  Reset (synchronous, active low) clears parse state, valids and sticky flags.
//  o_ready drops only when both the snapshot and the result stage are full
//  and the output is stalled.
// ============================================================================
`default_nettype none

module obd_pid_response_decoder_top
    import obd_prd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_char_code,
    input  wire logic                 i_end_of_response,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_status,
    output logic [7:0]                o_pid_code,
    output logic signed [VALUE_W-1:0] o_value_q8,
    output logic                      o_online_seen,
    output logic                      o_offline_seen
);

    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    obd_prd_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_char_code       (i_char_code),
        .i_end_of_response (i_end_of_response),
        .o_snap_valid      (snap_valid),
        .i_snap_ready      (snap_ready),
        .o_snap            (snap)
    );

    obd_prd_decoder u_decoder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_snap_valid   (snap_valid),
        .o_snap_ready   (snap_ready),
        .i_snap         (snap),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_pid_code     (o_pid_code),
        .o_value_q8     (o_value_q8),
        .o_online_seen  (o_online_seen),
        .o_offline_seen (o_offline_seen)
    );

endmodule

`default_nettype wire

[sv/obd_prd_checker.sv]
// ============================================================================
// obd_prd_checker
// Port-level checks on the decoder top, attached by bind.
// ============================================================================
`default_nettype none

module obd_prd_checker
    import obd_prd_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire logic [1:0]           o_status,
    input wire logic [7:0]           o_pid_code,
    input wire logic signed [VALUE_W-1:0] o_value_q8,
    input wire logic                 o_online_seen,
    input wire logic                 o_offline_seen
);

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_pid_code)
                                && $stable(o_value_q8))
        else $error("output transaction changed while stalled");

    a_online_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_online_seen |=> o_online_seen)
        else $error("online flag cleared");

    a_no_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NO_HDR |->
            o_offline_seen && o_pid_code == 8'd0 && o_value_q8 == '0)
        else $error("no-header result inconsistent");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_UNK || o_status == ST_SHORT) |->
            o_online_seen && o_value_q8 == '0)
        else $error("error result carries a value");

    a_ok_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_online_seen)
        else $error("decoded result without online flag");

endmodule

bind obd_pid_response_decoder_top obd_prd_checker u_obd_prd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_pid_code     (o_pid_code),
    .o_value_q8     (o_value_q8),
    .o_online_seen  (o_online_seen),
    .o_offline_seen (o_offline_seen)
);

`default_nettype wire

[tb/obd_pid_response_decoder_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// obd_pid_response_decoder_top_test
// Self-checking testbench for the OBD-II mode 01 response decoder. Response
// text is sent one character per transaction. A local decoder predicts each
// result and a monitor checks every output transaction against it, field by
// field. Directed responses cover every PID, every status, the odd pair
// readings and the character filter. Random responses follow, with input
// gaps, output stalls and one long output hold-off.
// ============================================================================

module obd_pid_response_decoder_top_test;
    import obd_prd_pkg::*;

    localparam logic [7:0] CH_G = 8'h47;

    typedef enum logic [1:0] {
        HUNT_HEADER,
        TAKE_PID,
        TAKE_DATA
    } t_parse_state;

    typedef struct {
        logic [1:0]               status;
        logic [7:0]               pid;
        logic signed [VALUE_W-1:0] value;
        logic                     online;
        logic                     offline;
    } t_decode_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [7:0]                i_char_code;
    logic                      i_end_of_response;
    logic                      o_valid;
    logic                      i_ready;
    logic [1:0]                o_status;
    logic [7:0]                o_pid_code;
    logic signed [VALUE_W-1:0] o_value_q8;
    logic                      o_online_seen;
    logic                      o_offline_seen;

    obd_pid_response_decoder_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_char_code       (i_char_code),
        .i_end_of_response (i_end_of_response),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_pid_code        (o_pid_code),
        .o_value_q8        (o_value_q8),
        .o_online_seen     (o_online_seen),
        .o_offline_seen    (o_offline_seen)
    );

    // Predictor state
    t_parse_state parse_state    = HUNT_HEADER;
    logic         after_four     = 1'b0;
    logic [7:0]   pid_text [2];
    logic [7:0]   data_text [4];
    logic [1:0]   pid_len        = 2'd0;
    logic [2:0]   data_len       = 3'd0;
    logic         online_sticky  = 1'b0;
    logic         offline_sticky = 1'b0;

    t_decode_result pending_results [$];
    logic [7:0]     resp_text [$];

    int errors         = 0;
    int chars_sent     = 0;
    int responses_sent = 0;
    int results_seen   = 0;
    int status_count [4] = '{0, 0, 0, 0};
    int hold_request   = 0;
    bit idle_enable    = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic int digit_of(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // strtoul-style base-16 read of a two-character text, kept to 8 bits
    function automatic logic [7:0] read_hex_pair(input logic [7:0] c0, input logic [7:0] c1);
        int d0;
        int d1;
        d0 = digit_of(c0);
        d1 = digit_of(c1);
        if (d0 >= 0) return (d1 >= 0) ? 8'(d0 * 16 + d1) : 8'(d0);
        if (c0 == CH_TAB || c0 == CH_VT || c0 == CH_FF || c0 == CH_PLUS)
            return (d1 >= 0) ? 8'(d1) : 8'd0;
        if (c0 == CH_MINUS) return (d1 >= 0) ? 8'(256 - d1) : 8'd0;
        return 8'd0;
    endfunction

    task automatic decode_char(input logic [7:0] raw, input logic last);
        logic [7:0]     ch;
        logic [7:0]     pid;
        int             a;
        int             b;
        int             val;
        logic           need4;
        logic           known;
        t_decode_result r;
        ch = raw;
        if (!(ch == CH_SPACE || ch == CH_GT || ch == CH_CR || ch == CH_LF)) begin
            if (ch >= CH_LA && ch <= CH_LZ) ch = ch - CASE_OFS;
            case (parse_state)
                TAKE_PID: begin
                    pid_text[pid_len[0]] = ch;
                    pid_len++;
                    if (pid_len >= 2) parse_state = TAKE_DATA;
                end
                TAKE_DATA: begin
                    if (data_len < 4) begin
                        data_text[data_len[1:0]] = ch;
                        data_len++;
                    end
                end
                default: begin
                    if (ch == CH_1 && after_four) parse_state = TAKE_PID;
                    after_four = (ch == CH_4);
                end
            endcase
        end
        if (!last) return;

        pid = 8'd0;
        val = 0;
        if (parse_state != TAKE_DATA) begin
            offline_sticky = 1'b1;
            r.status = ST_NO_HDR;
        end else begin
            pid   = read_hex_pair(pid_text[0], pid_text[1]);
            a     = (data_len >= 2) ? read_hex_pair(data_text[0], data_text[1]) : 0;
            b     = (data_len >= 4) ? read_hex_pair(data_text[2], data_text[3]) : 0;
            need4 = 1'b0;
            known = 1'b1;
            case (pid)
                PID_RPM:      begin need4 = 1'b1; val = ((a * 256 + b) / 4) * 256; end
                PID_SPEED:    val = a * 256;
                PID_COOLANT:  val = (a - 40) * 256;
                PID_LOAD:     val = (a * 25600) / 255;
                PID_TIMING:   val = a * 128 - 16384;
                PID_THROTTLE: val = (a * 25600) / 255;
                PID_VOLTAGE:  begin need4 = 1'b1; val = ((a * 256 + b) * 32) / 125; end
                PID_FUELTRIM: val = a * 200 - 25600;
                PID_MAP:      val = a * 256;
                default:      known = 1'b0;
            endcase
            if (!known) begin
                r.status = ST_UNK;
                val = 0;
            end else if (data_len < (need4 ? 3'd4 : 3'd2)) begin
                r.status = ST_SHORT;
                val = 0;
            end else begin
                r.status = ST_OK;
            end
            online_sticky = 1'b1;
        end
        r.pid     = pid;
        r.value   = val[VALUE_W-1:0];
        r.online  = online_sticky;
        r.offline = offline_sticky;
        pending_results.push_back(r);
        parse_state = HUNT_HEADER;
        after_four  = 1'b0;
        pid_len     = 2'd0;
        data_len    = 3'd0;
    endtask

    // Output side: random stalls plus the long hold-off on request
    initial begin : ready_driver
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else begin
                i_ready = 1'b1;
                if (idle_enable && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_decode_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                status_count[want.status]++;
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_pid_code !== want.pid)
                    report_mismatch("pid_code", o_pid_code, want.pid);
                if (o_value_q8 !== want.value)
                    report_mismatch("value_q8", int'(o_value_q8), int'(want.value));
                if (o_online_seen !== want.online)
                    report_mismatch("online_seen", o_online_seen, want.online);
                if (o_offline_seen !== want.offline)
                    report_mismatch("offline_seen", o_offline_seen, want.offline);
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid           = 1'b1;
        i_char_code       = ch;
        i_end_of_response = last;
        do @(posedge i_clk); while (!o_ready);
        decode_char(ch, last);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < resp_text.size(); i++)
            send_char(resp_text[i], i == resp_text.size() - 1);
        responses_sent++;
    endtask

    task automatic send_response(input string s);
        resp_text.delete();
        for (int i = 0; i < s.len(); i++)
            resp_text.push_back(s[i]);
        send_text();
    endtask

    function automatic logic [7:0] hex_ascii(input logic [3:0] n, input logic lower);
        if (n < 4'd10) return CH_0 + 8'(n);
        return (lower ? CH_LA : CH_UA) + 8'(n - 4'd10);
    endfunction

    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 6))
            0:       return CH_TAB;
            1:       return CH_VT;
            2:       return CH_FF;
            3:       return CH_PLUS;
            4:       return CH_MINUS;
            5:       return CH_G;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_known_pid();
        case ($urandom_range(0, 8))
            0:       return PID_RPM;
            1:       return PID_SPEED;
            2:       return PID_COOLANT;
            3:       return PID_LOAD;
            4:       return PID_TIMING;
            5:       return PID_THROTTLE;
            6:       return PID_VOLTAGE;
            7:       return PID_FUELTRIM;
            default: return PID_MAP;
        endcase
    endfunction

    task automatic push_digit(input logic [3:0] n, input int odd_pct);
        if ($urandom_range(0, 99) < odd_pct) resp_text.push_back(odd_char());
        else resp_text.push_back(hex_ascii(n, 1'($urandom_range(0, 1))));
    endtask

    task automatic push_sep();
        case ($urandom_range(0, 7))
            0:       resp_text.push_back(CH_CR);
            1:       resp_text.push_back(CH_LF);
            2:       resp_text.push_back(CH_GT);
            default: resp_text.push_back(CH_SPACE);
        endcase
    endtask

    // Mostly well-formed responses with random content; some noise and
    // some truncated ones
    task automatic random_response();
        int         kind;
        int         ndata;
        int         cut;
        logic [7:0] pid;
        logic       need4;
        resp_text.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) resp_text.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 3)) push_digit(4'($urandom_range(0, 15)), 0);
                resp_text.push_back(CH_SPACE);
            end
            resp_text.push_back(CH_4);
            if ($urandom_range(0, 3) == 0) push_sep();
            resp_text.push_back(CH_1);
            if ($urandom_range(0, 1)) push_sep();
            pid = ($urandom_range(0, 4) != 0) ? pick_known_pid() : 8'($urandom_range(0, 255));
            push_digit(pid[7:4], 4);
            push_digit(pid[3:0], 4);
            if ($urandom_range(0, 1)) push_sep();
            need4 = (pid == PID_RPM || pid == PID_VOLTAGE);
            ndata = ($urandom_range(0, 3) != 0) ? (need4 ? 4 : 2) : $urandom_range(0, 6);
            for (int i = 0; i < ndata; i++) begin
                push_digit(4'($urandom_range(0, 15)), 4);
                if (i % 2 == 1 && $urandom_range(0, 1)) push_sep();
            end
            if ($urandom_range(0, 2) == 0) resp_text.push_back(CH_CR);
            if ($urandom_range(0, 2) == 0) resp_text.push_back(CH_LF);
            if ($urandom_range(0, 2) == 0) resp_text.push_back(CH_GT);
            if (kind == 1) begin
                cut = $urandom_range(1, resp_text.size());
                while (resp_text.size() > cut) void'(resp_text.pop_back());
            end
        end
        send_text();
    endtask

    task automatic test_decoded_pids();
        send_response("410CFFFF");
        send_response("410C0000");
        send_response("410DFF");
        send_response("410500");
        send_response("4104FF");
        send_response("410E00");
        send_response("4111ff");
        send_response("4142FFFF");
        send_response("410700");
        send_response("410BFF");
    endtask

    task automatic test_status_codes();
        send_response("4142AB");            // too few data digits
        send_response("41FF12");            // PID not decoded
        send_response("7E8");               // no header
        send_response("414");               // PID cut short
        send_response(">");                 // only a dropped character
        send_response("4 41 0c 1A F8\015\012>");
    endtask

    task automatic test_pair_reading();
        send_response("410D\0115");         // leading tab skipped
        send_response("410D-1");            // minus wraps modulo 256
        send_response("410D+G");
        send_response("410DG5");
        send_response("410D5G");
        send_response("410D\013\014");
        send_response("41-5AA");
        send_response("410D\341\377");      // high bytes are not digits
        send_response("410D12345678");      // extra data digits ignored
        send_response("410d7f");
    endtask

    // Output held off while input keeps coming, so the pipeline fills and
    // the input side stalls
    task automatic test_backpressure();
        idle_enable  = 1'b0;
        hold_request = 300;
        repeat (12) random_response();
        idle_enable  = 1'b1;
    endtask

    task automatic test_random_responses(input int target_chars);
        int start;
        start = chars_sent;
        while (chars_sent - start < target_chars) random_response();
    endtask

    task automatic test_steady_stream(input int target_chars);
        idle_enable = 1'b0;
        test_random_responses(target_chars);
    endtask

    task automatic finish_run();
        int waited;
        @(negedge i_clk);
        i_valid = 1'b0;
        waited  = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("Sent %0d characters in %0d responses; checked %0d results.",
                 chars_sent, responses_sent, results_seen);
        $display("Status mix: decoded %0d, no header %0d, unknown PID %0d, short data %0d.",
                 status_count[ST_OK], status_count[ST_NO_HDR],
                 status_count[ST_UNK], status_count[ST_SHORT]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_char_code       = 8'd0;
        i_end_of_response = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_decoded_pids();
        test_status_codes();
        test_pair_reading();
        test_backpressure();
        test_random_responses(250);
        test_steady_stream(100);
        finish_run();
    end

endmodule
